// ===== rtl/core/sspp_pkg.sv =====
// Shared types and constants of the servo status packet parser.
package sspp_pkg;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_ARM  = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TIMEOUT = 3'd1;
  localparam logic [2:0] ST_SHORT   = 3'd2;
  localparam logic [2:0] ST_MANY    = 3'd3;
  localparam logic [2:0] ST_CSUM    = 3'd4;

  localparam logic [7:0]  HDR_BYTE      = 8'hFF;
  localparam logic [7:0]  LEN_OVERHEAD  = 8'd2;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [15:0] TICK_SAT      = 16'hFFFF;

  typedef struct packed {
    logic [15:0] sum;
    logic        ge;
    logic        eq;
  } alu_res_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] servo_id;
    logic [7:0] error_byte;
    logic [4:0] param_count;
    logic [3:0] param_index;
    logic [7:0] param_byte;
    logic       param_valid;
    logic       last;
  } res_t;

endpackage

// ===== rtl/core/sspp_if.sv =====
// Beat interfaces of the servo status packet parser: input items and results.
interface sspp_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface sspp_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] servo_id;
  logic [7:0] error_byte;
  logic [4:0] param_count;
  logic [3:0] param_index;
  logic [7:0] param_byte;
  logic       param_valid;
  logic       last;

  modport source (output valid, output status, output servo_id, output error_byte,
                  output param_count, output param_index, output param_byte,
                  output param_valid, output last, input ready);
  modport sink (input valid, input status, input servo_id, input error_byte,
                input param_count, input param_index, input param_byte,
                input param_valid, input last, output ready);
endinterface

// ===== rtl/core/sspp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sspp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/sspp_alu.sv =====
// Shared 16-bit add and compare unit used by the parser sequencer.
module sspp_alu (
  input  logic [15:0]         a,
  input  logic [15:0]         b,
  output sspp_pkg::alu_res_t  res
);
  import sspp_pkg::*;

  always_comb begin
    res.sum = a + b;
    res.ge  = (a >= b);
    res.eq  = (a == b);
  end

endmodule

// ===== rtl/core/servo_status_packet_parser.sv =====
// Top level of the servo status packet parser: sequencer, state and result register.
//
// Input channel "item" carries mode and rx_byte: mode 0 is a received byte,
// mode 1 a timer tick, mode 2 arms a new receive; mode 3 and any byte or tick
// while no receive is armed are dropped. The cfg_wr_en/cfg_wr_data port loads
// the timeout in ticks (reset 100); write it only while the block is idle.
// Output channel "result" carries one beat per parameter byte of a good
// packet, or one beat with a status code for an empty packet or an error.
// Every step goes through one shared add/compare unit, one operation a cycle,
// and ready is low while a step is in flight: an arm, an ignored item, a header
// or id byte need no step; a length byte adds, an error byte adds and checks the
// length, a parameter byte adds, counts and compares, a tick counts and compares,
// a checksum byte compares. A good packet then drains its parameters from the
// buffer RAM. Results sit in an output register, so an item is taken while a
// result waits; a step that has to emit holds until the register frees.
// Reset (synchronous, rst high) returns to idle with the output empty.
module servo_status_packet_parser #(
  parameter int MAX_PARAMS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  sspp_item_if.sink            item,
  sspp_result_if.source        result
);
  import sspp_pkg::*;

  localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int CW = $clog2(MAX_PARAMS + 1);
  localparam logic [7:0] MAX_CNT = 8'(MAX_PARAMS);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_HUNT  = 3'd1;
  localparam logic [2:0] PH_ID    = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_ERR   = 3'd4;
  localparam logic [2:0] PH_PARAM = 3'd5;
  localparam logic [2:0] PH_SUM   = 3'd6;

  localparam logic [3:0] S_WAIT     = 4'd0;
  localparam logic [3:0] S_TICK_INC = 4'd1;
  localparam logic [3:0] S_TICK_CMP = 4'd2;
  localparam logic [3:0] S_ADD      = 4'd3;
  localparam logic [3:0] S_ERRCHK   = 4'd4;
  localparam logic [3:0] S_PINC     = 4'd5;
  localparam logic [3:0] S_PCMP     = 4'd6;
  localparam logic [3:0] S_CHK      = 4'd7;
  localparam logic [3:0] S_RD       = 4'd8;
  localparam logic [3:0] S_DRN      = 4'd9;

  logic [3:0]    seq;
  logic [2:0]    phase;
  logic          prev_ff;
  logic [15:0]   elapsed;
  logic [15:0]   timeout;
  logic [7:0]    pkt_id;
  logic [7:0]    pkt_len;
  logic [7:0]    pkt_err;
  logic [CW-1:0] prcv;
  logic [CW-1:0] didx;
  logic [7:0]    run_sum;
  logic [7:0]    byte_r;
  logic          out_valid;
  res_t          out_res;

  logic [7:0]    count;
  logic          accept;
  logic          slot_free;
  logic          emit;
  logic [15:0]   alu_a;
  logic [15:0]   alu_b;
  alu_res_t      alu;
  logic          ram_wr_en;
  logic [7:0]    ram_rd_data;
  logic          drain_last;

  function automatic res_t fail_res(input logic [2:0] st);
    res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  assign count     = pkt_len - LEN_OVERHEAD;
  assign accept    = item.valid && item.ready;
  assign slot_free = !out_valid || result.ready;
  assign item.ready = (seq == S_WAIT);
  assign drain_last = (alu.sum == {8'd0, count});
  assign ram_wr_en = accept && (item.mode == MODE_BYTE) && (phase == PH_PARAM) &&
                     (prcv < CW'(MAX_PARAMS));

  always_comb begin
    emit = 1'b0;
    case (seq)
      S_TICK_CMP: emit = alu.ge;
      S_ERRCHK:   emit = (pkt_len < LEN_OVERHEAD) || (count > MAX_CNT);
      S_CHK:      emit = !alu.eq || (count == 8'd0);
      S_DRN:      emit = 1'b1;
      default:    emit = 1'b0;
    endcase
  end

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (seq)
      S_TICK_INC: begin
        alu_a = elapsed;
        alu_b = {15'd0, (elapsed != TICK_SAT)};
      end
      S_TICK_CMP: begin
        alu_a = elapsed;
        alu_b = timeout;
      end
      S_ADD: begin
        alu_a = {8'd0, run_sum};
        alu_b = {8'd0, byte_r};
      end
      S_PINC: begin
        alu_a = 16'(prcv);
        alu_b = 16'd1;
      end
      S_PCMP: begin
        alu_a = 16'(prcv);
        alu_b = {8'd0, count};
      end
      S_CHK: begin
        alu_a = {8'd0, ~run_sum};
        alu_b = {8'd0, byte_r};
      end
      S_DRN: begin
        alu_a = 16'(didx);
        alu_b = 16'd1;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  sspp_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  sspp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PARAMS)
  ) u_buf (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (prcv[AW-1:0]),
    .wr_data (item.rx_byte),
    .rd_en   (seq == S_RD),
    .rd_addr (didx[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= S_WAIT;
      phase     <= PH_IDLE;
      prev_ff   <= 1'b0;
      elapsed   <= '0;
      timeout   <= TIMEOUT_RESET;
      pkt_id    <= '0;
      pkt_len   <= '0;
      pkt_err   <= '0;
      prcv      <= '0;
      didx      <= '0;
      run_sum   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout <= cfg_wr_data;
      end
      if (emit && slot_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (seq)
        S_WAIT: begin
          if (accept) begin
            byte_r <= item.rx_byte;
            if (item.mode == MODE_ARM) begin
              phase   <= PH_HUNT;
              prev_ff <= 1'b0;
              elapsed <= '0;
              prcv    <= '0;
              run_sum <= '0;
            end else if (item.mode == MODE_TICK && phase != PH_IDLE) begin
              seq <= S_TICK_INC;
            end else if (item.mode == MODE_BYTE && phase != PH_IDLE) begin
              case (phase)
                PH_HUNT: begin
                  if (prev_ff && item.rx_byte == HDR_BYTE) begin
                    phase <= PH_ID;
                  end else begin
                    prev_ff <= (item.rx_byte == HDR_BYTE);
                  end
                end
                PH_ID: begin
                  pkt_id  <= item.rx_byte;
                  run_sum <= item.rx_byte;
                  phase   <= PH_LEN;
                end
                PH_LEN: begin
                  pkt_len <= item.rx_byte;
                  seq     <= S_ADD;
                end
                PH_ERR: begin
                  pkt_err <= item.rx_byte;
                  seq     <= S_ADD;
                end
                PH_PARAM: begin
                  seq <= S_ADD;
                end
                PH_SUM: begin
                  seq <= S_CHK;
                end
                default: begin
                  phase <= PH_IDLE;
                end
              endcase
            end
          end
        end
        S_TICK_INC: begin
          elapsed <= alu.sum;
          seq     <= S_TICK_CMP;
        end
        S_TICK_CMP: begin
          if (!alu.ge) begin
            seq <= S_WAIT;
          end else if (slot_free) begin
            out_res   <= fail_res(ST_TIMEOUT);
            phase     <= PH_IDLE;
            seq       <= S_WAIT;
          end
        end
        S_ADD: begin
          run_sum <= alu.sum[7:0];
          case (phase)
            PH_LEN: begin
              phase <= PH_ERR;
              seq   <= S_WAIT;
            end
            PH_ERR: begin
              seq <= S_ERRCHK;
            end
            default: begin
              seq <= S_PINC;
            end
          endcase
        end
        S_ERRCHK: begin
          if (pkt_len < LEN_OVERHEAD) begin
            if (slot_free) begin
              out_res   <= fail_res(ST_SHORT);
              phase     <= PH_IDLE;
              seq       <= S_WAIT;
            end
          end else if (count > MAX_CNT) begin
            if (slot_free) begin
              out_res   <= fail_res(ST_MANY);
              phase     <= PH_IDLE;
              seq       <= S_WAIT;
            end
          end else begin
            prcv  <= '0;
            phase <= (count == 8'd0) ? PH_SUM : PH_PARAM;
            seq   <= S_WAIT;
          end
        end
        S_PINC: begin
          prcv <= alu.sum[CW-1:0];
          seq  <= S_PCMP;
        end
        S_PCMP: begin
          if (alu.ge) begin
            phase <= PH_SUM;
          end
          seq <= S_WAIT;
        end
        S_CHK: begin
          if (!alu.eq || count == 8'd0) begin
            if (slot_free) begin
              out_res.status      <= alu.eq ? ST_OK : ST_CSUM;
              out_res.servo_id    <= pkt_id;
              out_res.error_byte  <= pkt_err;
              out_res.param_count <= 5'(count);
              out_res.param_index <= '0;
              out_res.param_byte  <= '0;
              out_res.param_valid <= 1'b0;
              out_res.last        <= 1'b1;
              phase               <= PH_IDLE;
              seq                 <= S_WAIT;
            end
          end else begin
            didx  <= '0;
            phase <= PH_IDLE;
            seq   <= S_RD;
          end
        end
        S_RD: begin
          seq <= S_DRN;
        end
        S_DRN: begin
          if (slot_free) begin
            out_res.status      <= ST_OK;
            out_res.servo_id    <= pkt_id;
            out_res.error_byte  <= pkt_err;
            out_res.param_count <= 5'(count);
            out_res.param_index <= 4'(didx);
            out_res.param_byte  <= ram_rd_data;
            out_res.param_valid <= 1'b1;
            out_res.last        <= drain_last;
            didx                <= alu.sum[CW-1:0];
            seq                 <= drain_last ? S_WAIT : S_RD;
          end
        end
        default: begin
          seq <= S_WAIT;
        end
      endcase
    end
  end

  assign result.valid       = out_valid;
  assign result.status      = out_res.status;
  assign result.servo_id    = out_res.servo_id;
  assign result.error_byte  = out_res.error_byte;
  assign result.param_count = out_res.param_count;
  assign result.param_index = out_res.param_index;
  assign result.param_byte  = out_res.param_byte;
  assign result.param_valid = out_res.param_valid;
  assign result.last        = out_res.last;

endmodule

// ===== rtl/core/sspp_check.sv =====
// Port-level assertion checker for the servo status packet parser, with its bind.
module sspp_check (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] status,
  input logic [3:0] param_index,
  input logic [7:0] param_byte,
  input logic       param_valid,
  input logic       last
);
  import sspp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat present after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(param_byte) &&
    $stable(param_index) && $stable(last))
    else $error("stalled result beat changed");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != ST_OK |-> last && !param_valid)
    else $error("error beat not a single final beat");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && !param_valid |-> param_index == 4'd0 && param_byte == 8'd0 && last)
    else $error("beat without parameter carries parameter data");

endmodule

bind servo_status_packet_parser sspp_check u_sspp_check (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .status      (result.status),
  .param_index (result.param_index),
  .param_byte  (result.param_byte),
  .param_valid (result.param_valid),
  .last        (result.last)
);
